// ===== hdl/sha_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 stream hasher.
// No dependencies; every other file of the hasher refers to this package.
package sha_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int CHAIN_N  = 8;
    localparam int WIN_N    = 16;
    localparam int ROUNDS   = 64;
    localparam int POS_W    = 6;
    localparam int ROUND_W  = 6;
    localparam int LEN_W    = 64;
    // Bit count of completed blocks, kept in units of 512 bits
    localparam int BLK_W    = LEN_W - POS_W - 3;

    localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

    localparam logic [WORD_W-1:0] CHAIN_IV [CHAIN_N] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } hasher_state_t;

    // Controls for the message schedule window
    typedef struct packed {
        logic              push_byte;
        logic              push_word;
        logic              step;
        logic [BYTE_W-1:0] data;
    } sched_ctl_t;

    // Controls for the round unit
    typedef struct packed {
        logic init;
        logic step;
    } round_ctl_t;

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== hdl/sha_in_if.sv =====
// Input channel of the SHA-256 stream hasher: one message byte and end mark.
// Depends on sha_pkg for the byte width.
interface sha_in_if;
    logic                      valid;
    logic                      ready;
    logic                      has_byte;
    logic [sha_pkg::BYTE_W-1:0] message_byte;
    logic                      end_of_message;

    modport source (output valid, output has_byte, output message_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input has_byte, input message_byte,
                    input end_of_message, output ready);
endinterface

// ===== hdl/sha_out_if.sv =====
// Output channel of the SHA-256 stream hasher: one digest word per transaction.
// Depends on sha_pkg for the word width.
interface sha_out_if;
    logic                      valid;
    logic                      ready;
    logic [sha_pkg::WORD_W-1:0] digest_word;
    logic                      digest_last;

    modport source (output valid, output digest_word, output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_last, output ready);
endinterface

// ===== hdl/sha256_stream_hasher_core.sv =====
// Top level of the SHA-256 stream hasher: sequencer, chaining words, padding.
// Depends on sha_pkg, sha_in_if, sha_out_if, sha_msg_sched and sha_round_unit.
//
// Usage:
//   msg carries one transaction per byte: has_byte marks message_byte valid,
//   end_of_message closes the message (with or without a byte). A bare end
//   mark with nothing before it hashes the empty message. A transaction with
//   neither flag set changes nothing.
//   digest returns eight 32-bit words, word 0 first, digest_last on word 7.
// Flow:
//   Every 64th byte starts a compression: 64 rounds through the single round
//   unit, then one fold. After the end mark, padding is fed byte by byte up
//   to the block end, followed by one compression, or two when the length
//   does not fit in the last block, before digest word 0 is shown.
//   msg.ready is high only while the block waits for message bytes.
// Reset and stall:
//   rst_n clears the chaining words to the initial hash values and the
//   counters to zero. While the receiver holds digest.ready low, the current
//   word stays on the port and no new byte is taken; after word 7 is taken
//   the chaining words and counters return to their reset values and the block accepts the next message.
module sha256_stream_hasher_core (
    input  logic           clk,
    input  logic           rst_n,
    sha_in_if.sink         msg,
    sha_out_if.source      digest
);

    sha_pkg::hasher_state_t     state_reg, state_next;
    logic [sha_pkg::WORD_W-1:0] chain_reg  [sha_pkg::CHAIN_N];
    logic [sha_pkg::WORD_W-1:0] chain_next [sha_pkg::CHAIN_N];
    logic [sha_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [sha_pkg::BLK_W-1:0]  blk_cnt_reg, blk_cnt_next;
    logic [sha_pkg::LEN_W-1:0]  total_reg, total_next;
    logic [sha_pkg::ROUND_W-1:0] round_reg, round_next;
    logic [2:0]                 out_idx_reg, out_idx_next;
    logic                       first_reg, first_next;
    logic                       len_ok_reg, len_ok_next;
    logic                       end_pend_reg, end_pend_next;
    logic                       pad_blk_reg, pad_blk_next;

    logic                       in_go;
    logic                       out_go;
    logic                       byte_go;
    logic [sha_pkg::BYTE_W-1:0] byte_val;
    logic                       round_init;
    logic                       pos_last;

    sha_pkg::sched_ctl_t        sched_ctl;
    sha_pkg::round_ctl_t        round_ctl;
    logic [sha_pkg::WORD_W-1:0] w_cur;
    logic [sha_pkg::WORD_W-1:0] work [sha_pkg::CHAIN_N];

    // Handshakes
    assign msg.ready          = (state_reg == sha_pkg::ST_IDLE);
    assign in_go              = msg.valid && msg.ready;
    assign digest.valid       = (state_reg == sha_pkg::ST_OUT);
    assign digest.digest_word = chain_reg[out_idx_reg];
    assign digest.digest_last = (out_idx_reg == 3'd7);
    assign out_go             = digest.valid && digest.ready;
    assign pos_last           = (pos_reg == {sha_pkg::POS_W{1'b1}});

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        chain_next    = chain_reg;
        pos_next      = pos_reg;
        blk_cnt_next  = blk_cnt_reg;
        total_next    = total_reg;
        round_next    = round_reg;
        out_idx_next  = out_idx_reg;
        first_next    = first_reg;
        len_ok_next   = len_ok_reg;
        end_pend_next = end_pend_reg;
        pad_blk_next  = pad_blk_reg;
        byte_go       = 1'b0;
        byte_val      = msg.message_byte;
        round_init    = 1'b0;

        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_go)
                begin
                    if (msg.has_byte)
                    begin
                        byte_go  = 1'b1;
                        pos_next = pos_reg + 1'b1;
                        if (pos_last)
                        begin
                            state_next    = sha_pkg::ST_ROUND;
                            round_init    = 1'b1;
                            round_next    = '0;
                            end_pend_next = msg.end_of_message;
                            pad_blk_next  = 1'b0;
                            blk_cnt_next  = blk_cnt_reg + 1'b1;
                        end
                        else if (msg.end_of_message)
                        begin
                            state_next = sha_pkg::ST_PAD;
                            first_next = 1'b1;
                        end
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = sha_pkg::ST_PAD;
                        first_next = 1'b1;
                    end
                end
            end

            sha_pkg::ST_PAD:
            begin
                byte_go  = 1'b1;
                pos_next = pos_reg + 1'b1;
                priority if (first_reg)
                begin
                    // Marker byte; latch the message length in bits
                    byte_val    = sha_pkg::PAD_MARK;
                    total_next  = {blk_cnt_reg, pos_reg, 3'b000};
                    len_ok_next = (pos_reg[5:3] != 3'b111);
                    first_next  = 1'b0;
                end
                else if (len_ok_reg && (pos_reg[5:3] == 3'b111))
                begin
                    // Length field, most significant byte first
                    byte_val   = total_reg[sha_pkg::LEN_W-1 -: sha_pkg::BYTE_W];
                    total_next = {total_reg[sha_pkg::LEN_W-sha_pkg::BYTE_W-1:0],
                                  {sha_pkg::BYTE_W{1'b0}}};
                end
                else
                begin
                    byte_val = '0;
                end
                if (pos_last)
                begin
                    state_next   = sha_pkg::ST_ROUND;
                    round_init   = 1'b1;
                    round_next   = '0;
                    pad_blk_next = 1'b1;
                end
            end

            sha_pkg::ST_ROUND:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == {sha_pkg::ROUND_W{1'b1}})
                begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end

            sha_pkg::ST_FOLD:
            begin
                for (int i = 0; i < sha_pkg::CHAIN_N; i++)
                begin
                    chain_next[i] = chain_reg[i] + work[i];
                end
                priority if (pad_blk_reg && len_ok_reg)
                begin
                    state_next   = sha_pkg::ST_OUT;
                    out_idx_next = '0;
                end
                else if (pad_blk_reg)
                begin
                    // Length did not fit: one more padding block
                    state_next  = sha_pkg::ST_PAD;
                    len_ok_next = 1'b1;
                end
                else if (end_pend_reg)
                begin
                    state_next    = sha_pkg::ST_PAD;
                    first_next    = 1'b1;
                    end_pend_next = 1'b0;
                end
                else
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end

            sha_pkg::ST_OUT:
            begin
                if (out_go)
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                    if (out_idx_reg == 3'd7)
                    begin
                        state_next   = sha_pkg::ST_IDLE;
                        chain_next   = sha_pkg::CHAIN_IV;
                        blk_cnt_next = '0;
                        pos_next     = '0;
                        end_pend_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha_pkg::ST_IDLE;
            chain_reg    <= sha_pkg::CHAIN_IV;
            pos_reg      <= '0;
            blk_cnt_reg  <= '0;
            round_reg    <= '0;
            out_idx_reg  <= '0;
            first_reg    <= 1'b0;
            len_ok_reg   <= 1'b0;
            end_pend_reg <= 1'b0;
            pad_blk_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chain_reg    <= chain_next;
            pos_reg      <= pos_next;
            blk_cnt_reg  <= blk_cnt_next;
            round_reg    <= round_next;
            out_idx_reg  <= out_idx_next;
            first_reg    <= first_next;
            len_ok_reg   <= len_ok_next;
            end_pend_reg <= end_pend_next;
            pad_blk_reg  <= pad_blk_next;
        end
    end

    // Length shift register
    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
    end

    // Datapath control
    assign sched_ctl.push_byte = byte_go;
    assign sched_ctl.push_word = byte_go && (pos_reg[1:0] == 2'b11);
    assign sched_ctl.step      = (state_reg == sha_pkg::ST_ROUND);
    assign sched_ctl.data      = byte_val;
    assign round_ctl.init      = round_init;
    assign round_ctl.step      = (state_reg == sha_pkg::ST_ROUND);

    sha_msg_sched u_sched (
        .clk   (clk),
        .ctl   (sched_ctl),
        .w_cur (w_cur)
    );

    sha_round_unit u_round (
        .clk   (clk),
        .ctl   (round_ctl),
        .chain (chain_reg),
        .k_cur (sha_pkg::ROUND_K[round_reg]),
        .w_cur (w_cur),
        .work  (work)
    );

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> !msg.ready)
        else $error("input open while digest words pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ROUND) && (round_reg == {sha_pkg::ROUND_W{1'b1}})
        |=> (state_reg == sha_pkg::ST_FOLD))
        else $error("compression did not end after the last round");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_FOLD) |-> (pos_reg == '0))
        else $error("block compressed while not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_go && digest.digest_last
        |=> (chain_reg[0] == sha_pkg::CHAIN_IV[0]) && (blk_cnt_reg == '0) && msg.ready)
        else $error("hasher not restored after digest");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_FOLD) && !pad_blk_reg && end_pend_reg
        |=> (state_reg == sha_pkg::ST_PAD) && first_reg)
        else $error("pending end mark not padded");

endmodule

// ===== hdl/sha_msg_sched.sv =====
// Message schedule: packs bytes into words and keeps the 16-word window
// that produces one schedule word per round. Depends on sha_pkg.
module sha_msg_sched (
    input  logic                       clk,
    input  sha_pkg::sched_ctl_t        ctl,
    output logic [sha_pkg::WORD_W-1:0] w_cur
);

    logic [sha_pkg::WORD_W-1:0] window_reg [sha_pkg::WIN_N];
    logic [23:0]                acc_reg;
    logic [sha_pkg::WORD_W-1:0] w_new;

    assign w_cur = window_reg[0];

    // Next schedule word from taps t, t+1, t+9, t+14
    assign w_new = window_reg[0] + sha_pkg::small_sigma0(window_reg[1])
                 + window_reg[9] + sha_pkg::small_sigma1(window_reg[14]);

    // Window shift: schedule step during rounds, word push during loading
    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            for (int i = 0; i < sha_pkg::WIN_N - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[sha_pkg::WIN_N-1] <= w_new;
        end
        else if (ctl.push_word)
        begin
            for (int i = 0; i < sha_pkg::WIN_N - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[sha_pkg::WIN_N-1] <= {acc_reg, ctl.data};
        end
    end

    // Byte packing, big-endian
    always_ff @(posedge clk)
    begin
        if (ctl.push_byte)
        begin
            acc_reg <= {acc_reg[15:0], ctl.data};
        end
    end

endmodule

// ===== hdl/sha_round_unit.sv =====
// Shared SHA-256 round unit: eight working words, one round per cycle.
// Depends on sha_pkg for the round functions and control struct.
module sha_round_unit (
    input  logic                       clk,
    input  sha_pkg::round_ctl_t        ctl,
    input  logic [sha_pkg::WORD_W-1:0] chain [sha_pkg::CHAIN_N],
    input  logic [sha_pkg::WORD_W-1:0] k_cur,
    input  logic [sha_pkg::WORD_W-1:0] w_cur,
    output logic [sha_pkg::WORD_W-1:0] work [sha_pkg::CHAIN_N]
);

    logic [sha_pkg::WORD_W-1:0] work_reg [sha_pkg::CHAIN_N];
    logic [sha_pkg::WORD_W-1:0] choose;
    logic [sha_pkg::WORD_W-1:0] major;
    logic [sha_pkg::WORD_W-1:0] sum1;
    logic [sha_pkg::WORD_W-1:0] sum2;

    assign work = work_reg;

    // Round arithmetic
    assign choose = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign major  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                  ^ (work_reg[1] & work_reg[2]);
    assign sum1   = work_reg[7] + sha_pkg::big_sigma1(work_reg[4]) + choose + k_cur + w_cur;
    assign sum2   = sha_pkg::big_sigma0(work_reg[0]) + major;

    // Load from chain at block start, then rotate through the rounds
    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            work_reg <= chain;
        end
        else if (ctl.step)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + sum1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= sum1 + sum2;
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench for sha256_stream_hasher_core: streams messages byte by byte and checks
// every digest word against a SHA-256 model kept in a scoreboard class.
// Depends on sha_pkg, sha_in_if, sha_out_if and the hasher RTL.
`timescale 1ns / 100ps

module tb;

    localparam int HALF_PERIOD = 2;
    // Settle time after the last digest word: padding plus two compressions
    localparam int TAIL_CYCLES = 300;
    // Receiver hold-off long enough for the block to fill up and stall its input
    localparam int LONG_HOLD   = 600;
    localparam int HOLD_AFTER  = 48;

    // Message lengths around the padding and block boundaries
    localparam int BOUNDARY_LEN [8] = '{55, 56, 57, 63, 64, 65, 119, 128};

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Hash state model plus the queue of digest words still owed by the block
    class digest_scoreboard;
        logic [31:0] chain [8];
        logic [7:0]  blk [64];
        int          fill;
        logic [63:0] bits_done;
        logic [31:0] word_q [$];
        logic        last_q [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
            begin
                chain[i] = SHA_IV[i];
            end
            fill      = 0;
            bits_done = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] v, int s);
            return (v >> s) | (v << (32 - s));
        endfunction

        // 64 rounds over the current block, folded into the chaining words
        function void compress();
            logic [31:0] w [64];
            logic [31:0] r [8];
            logic [31:0] s0, s1, t1, t2, ch, maj;
            for (int t = 0; t < 16; t++)
            begin
                w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            end
            for (int t = 16; t < 64; t++)
            begin
                s0   = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
                s1   = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = w[t-16] + s0 + w[t-7] + s1;
            end
            r = chain;
            for (int t = 0; t < 64; t++)
            begin
                s1   = ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25);
                ch   = (r[4] & r[5]) ^ (~r[4] & r[6]);
                t1   = r[7] + s1 + ch + SHA_K[t] + w[t];
                s0   = ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22);
                maj  = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
                t2   = s0 + maj;
                r[7] = r[6];
                r[6] = r[5];
                r[5] = r[4];
                r[4] = r[3] + t1;
                r[3] = r[2];
                r[2] = r[1];
                r[1] = r[0];
                r[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
            begin
                chain[i] = chain[i] + r[i];
            end
        endfunction

        // Absorb one accepted input transaction; an end mark queues eight words
        function void note_input(logic has_byte, logic [7:0] data, logic eom);
            logic [63:0] total_bits;
            int          pos;
            if (has_byte)
            begin
                blk[fill] = data;
                fill++;
                if (fill == 64)
                begin
                    compress();
                    bits_done = bits_done + 64'd512;
                    fill      = 0;
                end
            end
            if (!eom)
                return;

            // Pad: 0x80, zeros, big-endian length; extra block if it won't fit
            total_bits = bits_done + 64'(fill * 8);
            pos        = fill;
            blk[pos]   = 8'h80;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int k = 0; k < 8; k++)
            begin
                blk[63-k] = total_bits[8*k +: 8];
            end
            compress();

            for (int k = 0; k < 8; k++)
            begin
                word_q.push_back(chain[k]);
                last_q.push_back(k == 7);
            end
            restart();
        endfunction

        function void check_digest(logic [31:0] word, logic last);
            logic [31:0] exp_word;
            logic        exp_last;
            if (word_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected digest word %h last %b", word, last);
                return;
            end
            exp_word = word_q.pop_front();
            exp_last = last_q.pop_front();
            if (word !== exp_word || last !== exp_last)
            begin
                errors++;
                if (errors <= 10)
                    $display("digest mismatch: expected word %h last %b, got word %h last %b",
                             exp_word, exp_last, word, last);
            end
        endfunction

        function int pending();
            return word_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sha_in_if  msg_if ();
    sha_out_if digest_if ();

    digest_scoreboard sb;

    int burst_left = 0;
    int items_sent = 0;

    sha256_stream_hasher_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (digest_if)
    );

    always #HALF_PERIOD clk = ~clk;

    // Offer one transaction and wait for it to be taken; gaps fall between bursts
    task automatic offer(input logic has_byte, input logic [7:0] data, input logic eom);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        msg_if.valid          <= 1'b1;
        msg_if.has_byte       <= has_byte;
        msg_if.message_byte   <= data;
        msg_if.end_of_message <= eom;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        sb.note_input(has_byte, data, eom);
        burst_left--;
    endtask

    // Stop offering until every digest word owed has come back
    task automatic drain_results();
        msg_if.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // One message with random content, some idle transactions mixed in
    task automatic send_message(input int len, input logic end_on_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                offer(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            offer(1'b1, 8'($urandom_range(0, 255)), end_on_byte && (i == len - 1));
            items_sent++;
        end
        if (!end_on_byte || len == 0)
        begin
            offer(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            items_sent++;
        end
    endtask

    // Receiver: check each digest transaction, drive ready on its own pattern
    initial
    begin
        int   run_left;
        int   words_taken;
        logic long_done;
        run_left    = 0;
        words_taken = 0;
        long_done   = 1'b0;
        digest_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && digest_if.valid && digest_if.ready)
            begin
                sb.check_digest(digest_if.digest_word, digest_if.digest_last);
                words_taken++;
            end
            if (rst_n)
            begin
                if (run_left > 0)
                    run_left--;
                else if (!long_done && words_taken >= HOLD_AFTER)
                begin
                    digest_if.ready <= 1'b0;
                    run_left  = LONG_HOLD;
                    long_done = 1'b1;
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            digest_if.ready <= 1'b1;
                            run_left = $urandom_range(20, 60);
                        end
                        1, 2:
                        begin
                            digest_if.ready <= 1'b1;
                            run_left = $urandom_range(0, 3);
                        end
                        default:
                        begin
                            digest_if.ready <= 1'b0;
                            run_left = $urandom_range(0, 7);
                        end
                    endcase
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int len;
        int pick;
        int msgs;
        sb = new();
        rst_n                 <= 1'b0;
        msg_if.valid          <= 1'b0;
        msg_if.has_byte       <= 1'b0;
        msg_if.message_byte   <= 8'h00;
        msg_if.end_of_message <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty message, idle transaction, "abc" closed on its last byte
        offer(1'b0, 8'h00, 1'b1);
        offer(1'b0, 8'hff, 1'b0);
        offer(1'b1, 8'h61, 1'b0);
        offer(1'b1, 8'h62, 1'b0);
        offer(1'b1, 8'h63, 1'b1);
        // Extreme byte values, closed by a bare end mark
        offer(1'b1, 8'h00, 1'b0);
        offer(1'b1, 8'hff, 1'b0);
        offer(1'b1, 8'h55, 1'b0);
        offer(1'b1, 8'haa, 1'b0);
        offer(1'b0, 8'hff, 1'b1);
        // Idle then a one-byte message carrying its end mark
        offer(1'b0, 8'h5a, 1'b0);
        offer(1'b1, 8'hff, 1'b1);
        drain_results();

        // Random messages: mostly short, some right at the padding boundaries
        msgs = 0;
        while (items_sent < 170 || msgs < 6)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                len = $urandom_range(0, 12);
            else if (pick < 80)
                len = BOUNDARY_LEN[$urandom_range(0, 7)];
            else
                len = $urandom_range(13, 80);
            send_message(len, 1'($urandom_range(0, 1)));
            msgs++;
            if (msgs == 3)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** sha256_stream_hasher_core: PASSED **");
        else
            $display("** sha256_stream_hasher_core: FAILED **");
        $finish;
    end

    // Watchdog: ends a run that hangs and reports it as failed
    initial
    begin
        #1000000;
        $display("** sha256_stream_hasher_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sha_pkg.sv
hdl/sha_in_if.sv
hdl/sha_out_if.sv
hdl/sha_msg_sched.sv
hdl/sha_round_unit.sv
hdl/sha256_stream_hasher_core.sv
sim/tb.sv
